// ===== sv/rv32i_instruction_execute_macros.svh =====
// Assertion macros for the instruction executor.
`ifndef RV32I_INSTRUCTION_EXECUTE_MACROS_SVH
`define RV32I_INSTRUCTION_EXECUTE_MACROS_SVH
`ifndef SYNTHESIS
`define RV32IE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rv32ie: implication violated");
`define RV32IE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rv32ie: next-cycle check violated");
`else
`define RV32IE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RV32IE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/rv32ie_pkg.sv =====
package rv32ie_pkg;

    localparam int XLEN = 32;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_MISALIGNED = 3'd1;
    localparam logic [2:0] ST_ILLEGAL    = 3'd2;
    localparam logic [2:0] ST_EBREAK     = 3'd3;
    localparam logic [2:0] ST_ECALL      = 3'd4;
    localparam logic [2:0] ST_CSR        = 3'd5;

    // memory request kind and size
    localparam logic [1:0] MK_NONE  = 2'd0;
    localparam logic [1:0] MK_LOAD  = 2'd1;
    localparam logic [1:0] MK_STORE = 2'd2;
    localparam logic [1:0] SZ_BYTE  = 2'd0;
    localparam logic [1:0] SZ_HALF  = 2'd1;
    localparam logic [1:0] SZ_WORD  = 2'd2;

    // pending load extension kind
    localparam logic [1:0] LK_LBU = 2'd0;
    localparam logic [1:0] LK_LH  = 2'd1;
    localparam logic [1:0] LK_LHU = 2'd2;
    localparam logic [1:0] LK_LW  = 2'd3;

    // configuration register indexes
    localparam logic CFG_START_ADDRESS = 1'b0;
    localparam logic CFG_MULDIV_ENABLE = 1'b1;

    typedef enum logic [3:0] {
        OC_NONE, OC_ALU, OC_LUI, OC_AUIPC, OC_JAL, OC_JALR,
        OC_BRANCH, OC_LOAD, OC_STORE, OC_MULDIV
    } op_class_t;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_SLL, ALU_SRL, ALU_SRA, ALU_SLTU, ALU_XOR, ALU_OR, ALU_AND
    } alu_op_t;

    typedef enum logic [1:0] {
        MD_MUL, MD_MULH, MD_DIV, MD_REM
    } md_op_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_READ, BK_MUL, BK_MULH, BK_DIV, BK_OUT
    } bk_state_t;

    typedef struct packed {
        logic        cmd;
        logic [31:0] insn_word;
        logic [31:0] load_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_kind;
        logic [31:0] mem_addr;
        logic [1:0]  mem_size;
        logic [31:0] store_data;
        logic        rd_written;
        logic [4:0]  rd_index;
        logic [31:0] rd_value;
        logic [2:0]  status;
    } out_item_t;

    // decoded item handed from front to back
    typedef struct packed {
        logic        cmd;
        op_class_t   cls;
        alu_op_t     alu;
        md_op_t      md;
        logic        use_imm;
        logic [31:0] imm;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [2:0]  f3;
        logic [2:0]  st;
        logic [1:0]  lkind;
        logic [1:0]  msize;
        logic [31:0] load_word;
    } fe_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== sv/rv32ie_front.sv =====
module rv32ie_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rv32ie_pkg::in_item_t  s_data,
    input  rv32ie_pkg::q_status_t q_stat,
    output logic                  push,
    output rv32ie_pkg::fe_item_t  push_data
);

    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    logic [31:0] w;
    logic [6:0]  f7;
    logic [31:0] imm_i;

    assign s_ready = !q_stat.full;
    assign push    = s_valid && !q_stat.full;
    assign w       = s_data.insn_word;
    assign f7      = w[31:25];
    assign imm_i   = {{20{w[31]}}, w[31:20]};

    always_comb begin
        push_data           = '0;
        push_data.cmd       = s_data.cmd;
        push_data.load_word = s_data.load_word;
        push_data.rd        = w[11:7];
        push_data.rs1       = w[19:15];
        push_data.rs2       = w[24:20];
        push_data.f3        = w[14:12];
        push_data.cls       = rv32ie_pkg::OC_NONE;
        push_data.alu       = rv32ie_pkg::ALU_ADD;
        push_data.md        = rv32ie_pkg::MD_MUL;
        push_data.st        = rv32ie_pkg::ST_OK;
        case (w[6:0])
            OPC_OP_IMM: begin
                push_data.cls     = rv32ie_pkg::OC_ALU;
                push_data.use_imm = 1'b1;
                push_data.imm     = imm_i;
                case (w[14:12])
                    3'd0: push_data.alu = rv32ie_pkg::ALU_ADD;
                    3'd1: begin
                        if (f7 == 7'h00) push_data.alu = rv32ie_pkg::ALU_SLL;
                        else push_data.st = rv32ie_pkg::ST_ILLEGAL;
                    end
                    3'd3: push_data.alu = rv32ie_pkg::ALU_SLTU;
                    3'd4: push_data.alu = rv32ie_pkg::ALU_XOR;
                    3'd5: begin
                        if (f7 == 7'h00) push_data.alu = rv32ie_pkg::ALU_SRL;
                        else if (f7 == 7'h20) push_data.alu = rv32ie_pkg::ALU_SRA;
                        else push_data.st = rv32ie_pkg::ST_ILLEGAL;
                    end
                    3'd6: push_data.alu = rv32ie_pkg::ALU_OR;
                    3'd7: push_data.alu = rv32ie_pkg::ALU_AND;
                    default: push_data.st = rv32ie_pkg::ST_ILLEGAL;
                endcase
            end
            OPC_OP: begin
                push_data.cls = rv32ie_pkg::OC_ALU;
                if (f7 == 7'h00) begin
                    case (w[14:12])
                        3'd0: push_data.alu = rv32ie_pkg::ALU_ADD;
                        3'd1: push_data.alu = rv32ie_pkg::ALU_SLL;
                        3'd3: push_data.alu = rv32ie_pkg::ALU_SLTU;
                        3'd4: push_data.alu = rv32ie_pkg::ALU_XOR;
                        3'd6: push_data.alu = rv32ie_pkg::ALU_OR;
                        3'd7: push_data.alu = rv32ie_pkg::ALU_AND;
                        default: push_data.st = rv32ie_pkg::ST_ILLEGAL;
                    endcase
                end else if (f7 == 7'h20 && w[14:12] == 3'd0) begin
                    push_data.alu = rv32ie_pkg::ALU_SUB;
                end else if (f7 == 7'h01) begin
                    push_data.cls = rv32ie_pkg::OC_MULDIV;
                    case (w[14:12])
                        3'd0: push_data.md = rv32ie_pkg::MD_MUL;
                        3'd1: push_data.md = rv32ie_pkg::MD_MULH;
                        3'd4: push_data.md = rv32ie_pkg::MD_DIV;
                        3'd6: push_data.md = rv32ie_pkg::MD_REM;
                        default: push_data.st = rv32ie_pkg::ST_ILLEGAL;
                    endcase
                end else begin
                    push_data.st = rv32ie_pkg::ST_ILLEGAL;
                end
            end
            OPC_LUI: begin
                push_data.cls = rv32ie_pkg::OC_LUI;
                push_data.imm = {w[31:12], 12'b0};
            end
            OPC_AUIPC: begin
                push_data.cls = rv32ie_pkg::OC_AUIPC;
                push_data.imm = {w[31:12], 12'b0};
            end
            OPC_JAL: begin
                push_data.cls = rv32ie_pkg::OC_JAL;
                push_data.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR: begin
                push_data.cls = rv32ie_pkg::OC_JALR;
                push_data.imm = imm_i;
            end
            OPC_BRANCH: begin
                push_data.cls = rv32ie_pkg::OC_BRANCH;
                push_data.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                if (w[14:13] == 2'b01) push_data.st = rv32ie_pkg::ST_ILLEGAL;
            end
            OPC_LOAD: begin
                push_data.cls = rv32ie_pkg::OC_LOAD;
                push_data.imm = imm_i;
                case (w[14:12])
                    3'd4: begin
                        push_data.lkind = rv32ie_pkg::LK_LBU;
                        push_data.msize = rv32ie_pkg::SZ_BYTE;
                    end
                    3'd1: begin
                        push_data.lkind = rv32ie_pkg::LK_LH;
                        push_data.msize = rv32ie_pkg::SZ_HALF;
                    end
                    3'd5: begin
                        push_data.lkind = rv32ie_pkg::LK_LHU;
                        push_data.msize = rv32ie_pkg::SZ_HALF;
                    end
                    3'd2: begin
                        push_data.lkind = rv32ie_pkg::LK_LW;
                        push_data.msize = rv32ie_pkg::SZ_WORD;
                    end
                    default: push_data.st = rv32ie_pkg::ST_ILLEGAL;
                endcase
            end
            OPC_STORE: begin
                push_data.cls   = rv32ie_pkg::OC_STORE;
                push_data.imm   = {{20{w[31]}}, w[31:25], w[11:7]};
                push_data.msize = w[13:12];
                if (w[14] || w[13:12] == 2'b11) push_data.st = rv32ie_pkg::ST_ILLEGAL;
            end
            OPC_FENCE: begin
                if (w[14:13] != 2'b00) push_data.st = rv32ie_pkg::ST_ILLEGAL;
            end
            OPC_SYSTEM: begin
                if (w[14:12] == 3'd0) begin
                    if (w[31:20] == 12'd0) push_data.st = rv32ie_pkg::ST_ECALL;
                    else if (w[31:20] == 12'd1) push_data.st = rv32ie_pkg::ST_EBREAK;
                    else if (!(f7 == 7'h08 && w[24:20] == 5'h05))
                        push_data.st = rv32ie_pkg::ST_ILLEGAL;
                end else if (w[14:12] == 3'd4) begin
                    push_data.st = rv32ie_pkg::ST_ILLEGAL;
                end else begin
                    push_data.st = rv32ie_pkg::ST_CSR;
                end
            end
            default: push_data.st = rv32ie_pkg::ST_ILLEGAL;
        endcase
    end

endmodule

// ===== sv/rv32ie_fifo.sv =====
module rv32ie_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  rv32ie_pkg::fe_item_t  push_data,
    input  logic                  pop,
    output rv32ie_pkg::fe_item_t  head,
    output rv32ie_pkg::q_status_t q_stat
);

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);

    rv32ie_pkg::fe_item_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == (PW+1)'(DEPTH));

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== sv/rv32ie_div.sv =====
module rv32ie_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quo,
    output logic [31:0] rem
);

    localparam int W  = rv32ie_pkg::XLEN;
    localparam int CW = $clog2(W);

    logic          busy_reg, done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg, rem_reg, dsr_reg;
    logic [W:0]    part, diff;

    // one quotient bit per cycle, restoring
    assign part = {rem_reg, quo_reg[W-1]};
    assign diff = part - {1'b0, dsr_reg};
    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= part[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == CW'(W - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(W - 1)) busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/rv32ie_back.sv =====
module rv32ie_back #(
    parameter int REG_COUNT = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  rv32ie_pkg::fe_item_t  head,
    input  rv32ie_pkg::q_status_t q_stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rv32ie_pkg::out_item_t m_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int AW = $clog2(REG_COUNT);

    rv32ie_pkg::bk_state_t state_reg, state_next;
    rv32ie_pkg::fe_item_t  item_reg;
    rv32ie_pkg::out_item_t out_reg, res;

    logic [31:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0] rfa_reg, rfb_reg, a, b;
    logic [31:0] pc_reg, op_a_reg, op_b_reg;
    logic [63:0] prod_reg;
    logic        md_en_reg, pend_reg;
    logic [4:0]  pend_dest_reg;
    logic [1:0]  pend_kind_reg;

    logic        fin, wr_req, wr_en, pend_set, pend_clr, ld_ops, div_start, div_done;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val, opb, npc, ldv, ma, mb, dq, dr, mulh;
    logic [2:0]  st;
    logic        take;

    function automatic logic reg_ok(input logic [4:0] idx);
        return (idx != 5'd0) && ({1'b0, idx} < 6'(REG_COUNT));
    endfunction

    // register file, registered read at the queue head's sources
    always_ff @(posedge aclk) begin
        rfa_reg <= rf_mem[head.rs1[AW-1:0]];
        rfb_reg <= rf_mem[head.rs2[AW-1:0]];
        if (wr_en) rf_mem[wr_idx[AW-1:0]] <= wr_val;
    end

    assign a = (reg_ok(item_reg.rs1) && valid_reg[item_reg.rs1[AW-1:0]]) ? rfa_reg : '0;
    assign b = (reg_ok(item_reg.rs2) && valid_reg[item_reg.rs2[AW-1:0]]) ? rfb_reg : '0;
    assign opb = item_reg.use_imm ? item_reg.imm : b;
    assign ma  = a[31] ? (32'd0 - a) : a;
    assign mb  = b[31] ? (32'd0 - b) : b;
    assign mulh = prod_reg[63:32] - (op_a_reg[31] ? op_b_reg : 32'd0)
                - (op_b_reg[31] ? op_a_reg : 32'd0);

    rv32ie_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ma),
        .divisor  (mb),
        .done     (div_done),
        .quo      (dq),
        .rem      (dr)
    );

    always_comb begin
        case (pend_kind_reg)
            rv32ie_pkg::LK_LBU: ldv = {24'd0, item_reg.load_word[7:0]};
            rv32ie_pkg::LK_LH:  ldv = {{16{item_reg.load_word[15]}}, item_reg.load_word[15:0]};
            rv32ie_pkg::LK_LHU: ldv = {16'd0, item_reg.load_word[15:0]};
            default:            ldv = item_reg.load_word;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        fin        = 1'b0;
        wr_req     = 1'b0;
        wr_idx     = item_reg.rd;
        wr_val     = '0;
        pend_set   = 1'b0;
        pend_clr   = 1'b0;
        ld_ops     = 1'b0;
        div_start  = 1'b0;
        res        = '0;
        res.next_pc = pc_reg;
        st         = item_reg.st;
        npc        = pc_reg + 32'd4;
        take       = 1'b0;
        case (state_reg)
            rv32ie_pkg::BK_IDLE: begin
                if (!q_stat.empty) begin
                    pop        = 1'b1;
                    state_next = rv32ie_pkg::BK_READ;
                end
            end
            rv32ie_pkg::BK_READ: begin
                if (item_reg.cmd) begin
                    fin = 1'b1;
                    if (pend_reg) begin
                        wr_req   = 1'b1;
                        wr_idx   = pend_dest_reg;
                        wr_val   = ldv;
                        pend_clr = 1'b1;
                    end
                end else if (pend_reg) begin
                    fin = 1'b1;
                end else if (pc_reg[1:0] != 2'b00) begin
                    fin        = 1'b1;
                    res.status = rv32ie_pkg::ST_MISALIGNED;
                end else begin
                    if (item_reg.cls == rv32ie_pkg::OC_MULDIV && !md_en_reg)
                        st = rv32ie_pkg::ST_ILLEGAL;
                    fin = 1'b1;
                    if (st == rv32ie_pkg::ST_OK) begin
                        case (item_reg.cls)
                            rv32ie_pkg::OC_ALU: begin
                                wr_req = 1'b1;
                                case (item_reg.alu)
                                    rv32ie_pkg::ALU_ADD:  wr_val = a + opb;
                                    rv32ie_pkg::ALU_SUB:  wr_val = a - opb;
                                    rv32ie_pkg::ALU_SLL:  wr_val = a << opb[4:0];
                                    rv32ie_pkg::ALU_SRL:  wr_val = a >> opb[4:0];
                                    rv32ie_pkg::ALU_SRA:  wr_val = 32'($signed(a) >>> opb[4:0]);
                                    rv32ie_pkg::ALU_SLTU: wr_val = {31'd0, a < opb};
                                    rv32ie_pkg::ALU_XOR:  wr_val = a ^ opb;
                                    rv32ie_pkg::ALU_OR:   wr_val = a | opb;
                                    rv32ie_pkg::ALU_AND:  wr_val = a & opb;
                                    default:              wr_val = '0;
                                endcase
                            end
                            rv32ie_pkg::OC_LUI: begin
                                wr_req = 1'b1;
                                wr_val = item_reg.imm;
                            end
                            rv32ie_pkg::OC_AUIPC: begin
                                wr_req = 1'b1;
                                wr_val = item_reg.imm + pc_reg;
                            end
                            rv32ie_pkg::OC_JAL: begin
                                wr_req = 1'b1;
                                wr_val = pc_reg + 32'd4;
                                npc    = pc_reg + item_reg.imm;
                            end
                            rv32ie_pkg::OC_JALR: begin
                                wr_req = 1'b1;
                                wr_val = pc_reg + 32'd4;
                                npc    = (a + item_reg.imm) & ~32'd1;
                            end
                            rv32ie_pkg::OC_BRANCH: begin
                                case (item_reg.f3)
                                    3'd0:    take = (a == b);
                                    3'd1:    take = (a != b);
                                    3'd4:    take = ($signed(a) < $signed(b));
                                    3'd5:    take = !($signed(a) < $signed(b));
                                    3'd6:    take = (a < b);
                                    default: take = (a >= b);
                                endcase
                                if (take) npc = pc_reg + item_reg.imm;
                            end
                            rv32ie_pkg::OC_LOAD: begin
                                res.mem_kind = rv32ie_pkg::MK_LOAD;
                                res.mem_addr = a + item_reg.imm;
                                res.mem_size = item_reg.msize;
                                pend_set     = 1'b1;
                            end
                            rv32ie_pkg::OC_STORE: begin
                                res.mem_kind   = rv32ie_pkg::MK_STORE;
                                res.mem_addr   = a + item_reg.imm;
                                res.mem_size   = item_reg.msize;
                                res.store_data = b;
                            end
                            rv32ie_pkg::OC_MULDIV: begin
                                ld_ops = 1'b1;
                                if (item_reg.md == rv32ie_pkg::MD_MUL ||
                                        item_reg.md == rv32ie_pkg::MD_MULH) begin
                                    fin        = 1'b0;
                                    state_next = rv32ie_pkg::BK_MUL;
                                end else if (b == 32'd0) begin
                                    wr_req = 1'b1;
                                    wr_val = (item_reg.md == rv32ie_pkg::MD_REM) ? a : '1;
                                end else begin
                                    fin        = 1'b0;
                                    div_start  = 1'b1;
                                    state_next = rv32ie_pkg::BK_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (st == rv32ie_pkg::ST_ILLEGAL) begin
                        npc    = pc_reg;
                        res    = '0;
                        wr_req = 1'b0;
                    end
                    res.next_pc = npc;
                    res.status  = st;
                end
            end
            rv32ie_pkg::BK_MUL: begin
                state_next = rv32ie_pkg::BK_MULH;
            end
            rv32ie_pkg::BK_MULH: begin
                fin         = 1'b1;
                wr_req      = 1'b1;
                wr_val      = (item_reg.md == rv32ie_pkg::MD_MUL) ? prod_reg[31:0] : mulh;
                res.next_pc = npc;
            end
            rv32ie_pkg::BK_DIV: begin
                if (div_done) begin
                    fin         = 1'b1;
                    wr_req      = 1'b1;
                    res.next_pc = npc;
                    if (item_reg.md == rv32ie_pkg::MD_REM)
                        wr_val = op_a_reg[31] ? (32'd0 - dr) : dr;
                    else
                        wr_val = (op_a_reg[31] ^ op_b_reg[31]) ? (32'd0 - dq) : dq;
                end
            end
            rv32ie_pkg::BK_OUT: begin
                if (m_ready) state_next = rv32ie_pkg::BK_IDLE;
            end
            default: state_next = rv32ie_pkg::BK_IDLE;
        endcase
        wr_en = fin && wr_req && reg_ok(wr_idx);
        if (wr_en) begin
            res.rd_written = 1'b1;
            res.rd_index   = wr_idx;
            res.rd_value   = wr_val;
        end
        if (fin) state_next = rv32ie_pkg::BK_OUT;
    end

    assign m_valid = (state_reg == rv32ie_pkg::BK_OUT);
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (pop) item_reg <= head;
        if (fin) out_reg <= res;
        if (ld_ops) begin
            op_a_reg <= a;
            op_b_reg <= b;
        end
        prod_reg <= 64'(op_a_reg) * 64'(op_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rv32ie_pkg::BK_IDLE;
            pc_reg        <= '0;
            md_en_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            pend_dest_reg <= '0;
            pend_kind_reg <= rv32ie_pkg::LK_LBU;
            valid_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_index == rv32ie_pkg::CFG_START_ADDRESS) pc_reg <= cfg_data;
            else if (fin) pc_reg <= res.next_pc;
            if (cfg_wr_en && cfg_index == rv32ie_pkg::CFG_MULDIV_ENABLE)
                md_en_reg <= cfg_data[0];
            if (wr_en) valid_reg[wr_idx[AW-1:0]] <= 1'b1;
            if (pend_clr) pend_reg <= 1'b0;
            if (pend_set) begin
                pend_reg      <= 1'b1;
                pend_dest_reg <= item_reg.rd;
                pend_kind_reg <= item_reg.lkind;
            end
        end
    end

endmodule

// ===== sv/rv32i_instruction_execute.sv =====
// Channel   Dir  Payload                 Handshake
// s_        in   rv32ie_pkg::in_item_t   s_valid / s_ready
// m_        out  rv32ie_pkg::out_item_t  m_valid / m_ready
// cfg_      in   cfg_index, cfg_data     cfg_wr_en
//
// An item passes through issue, register read and execute, and result in the
// execute unit; MUL/MULH pass through the MUL and MULH states before the result,
// and DIV/REM with a nonzero divisor wait on the one-bit-per-cycle divider.
// Reset is synchronous, active low, and needs no clearing pass.
// The two-entry queue keeps accepting beats until full while a result waits on m_ready.
`include "rv32i_instruction_execute_macros.svh"
module rv32i_instruction_execute #(
    parameter int REG_COUNT = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rv32ie_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rv32ie_pkg::out_item_t m_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data
);

    rv32ie_pkg::fe_item_t  push_data, head;
    rv32ie_pkg::q_status_t q_stat;
    logic                  push, pop;

    // decode each beat into an operation class and immediate
    rv32ie_front u_front (
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // hold decoded items between decode and execute
    rv32ie_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .q_stat    (q_stat)
    );

    // execute against register file and pc, drive the result beat
    rv32ie_back #(
        .REG_COUNT (REG_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    `RV32IE_ASSERT_IMP(a_illegal_quiet, aclk, aresetn, m_valid && m_data.status == rv32ie_pkg::ST_ILLEGAL, !m_data.rd_written && m_data.mem_kind == rv32ie_pkg::MK_NONE)
    `RV32IE_ASSERT_IMP(a_no_x0_write, aclk, aresetn, m_valid && m_data.rd_written, m_data.rd_index != 5'd0)
    `RV32IE_ASSERT_IMP(a_store_ok, aclk, aresetn, m_valid && m_data.mem_kind == rv32ie_pkg::MK_STORE, m_data.status == rv32ie_pkg::ST_OK)
    `RV32IE_ASSERT_NXT(a_gap_after_beat, aclk, aresetn, m_valid && m_ready, !m_valid)

endmodule

// ===== tb/rv32ie_tb_pkg.sv =====
package rv32ie_tb_pkg;

    // major opcodes
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_OP_IMM = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 values
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_WFI    = 7'h08;
    localparam logic [6:0] F7_ALT    = 7'h20;

    // funct3 values, grouped by opcode
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    localparam logic [2:0] F3_MUL  = 3'd0;
    localparam logic [2:0] F3_MULH = 3'd1;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_REM  = 3'd6;

    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;

    localparam logic [2:0] F3_SW      = 3'd2;
    localparam logic [2:0] F3_FENCE_I = 3'd1;
    localparam logic [2:0] F3_PRIV    = 3'd0;
    localparam logic [2:0] F3_CSRRW   = 3'd1;
    localparam logic [2:0] F3_SYS_RSV = 3'd4;

    localparam logic [11:0] F12_ECALL  = 12'h000;
    localparam logic [11:0] F12_EBREAK = 12'h001;
    localparam logic [4:0]  RS2_WFI    = 5'h05;

endpackage

// ===== tb/rv32ie_checker.sv =====
module rv32ie_checker #(
    parameter int REG_COUNT = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  rv32ie_pkg::in_item_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  rv32ie_pkg::out_item_t m_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [31:0]           cfg_data,
    output int                    fail_count,
    output int                    pending_count
);
    import rv32ie_pkg::*;
    import rv32ie_tb_pkg::*;

    logic [31:0] regs [32];
    logic [31:0] prog_ctr;
    logic        muldiv_on;
    logic        load_busy;
    logic [4:0]  load_dest;
    logic [1:0]  load_kind;
    out_item_t   expected_results [$];

    function automatic logic [31:0] read_reg(logic [4:0] idx);
        if (idx == 5'd0 || idx >= REG_COUNT) return 32'd0;
        return regs[idx];
    endfunction

    function automatic logic write_reg(logic [4:0] idx, logic [31:0] val);
        if (idx == 5'd0 || idx >= REG_COUNT) return 1'b0;
        regs[idx] = val;
        return 1'b1;
    endfunction

    // Execute one beat against the shadow state and return its result.
    function automatic out_item_t execute_beat(in_item_t b);
        out_item_t          r;
        logic [31:0]        w, pc, a, bv, imm_i, imm, v, lw;
        logic [6:0]         opc, f7;
        logic [4:0]         rd, rs1, rs2;
        logic [2:0]         f3;
        logic               dowrite, take;
        logic signed [63:0] prod;
        r  = '0;
        w  = b.insn_word;
        lw = b.load_word;
        pc = prog_ctr;
        r.next_pc = pc;
        if (b.cmd) begin
            if (load_busy) begin
                case (load_kind)
                    LK_LBU:  v = {24'd0, lw[7:0]};
                    LK_LH:   v = {{16{lw[15]}}, lw[15:0]};
                    LK_LHU:  v = {16'd0, lw[15:0]};
                    default: v = lw;
                endcase
                if (write_reg(load_dest, v)) begin
                    r.rd_written = 1'b1;
                    r.rd_index   = load_dest;
                    r.rd_value   = v;
                end
                load_busy = 1'b0;
            end
            return r;
        end
        if (load_busy) return r;
        if (pc[1:0] != 2'b00) begin
            r.status = ST_MISALIGNED;
            return r;
        end
        opc   = w[6:0];
        rd    = w[11:7];
        f3    = w[14:12];
        rs1   = w[19:15];
        rs2   = w[24:20];
        f7    = w[31:25];
        a     = read_reg(rs1);
        bv    = read_reg(rs2);
        imm_i = {{20{w[31]}}, w[31:20]};
        r.next_pc = pc + 32'd4;
        v       = '0;
        dowrite = 1'b0;
        take    = 1'b0;
        case (opc)
            OPC_OP_IMM: begin
                dowrite = 1'b1;
                case (f3)
                    F3_ADD:  v = a + imm_i;
                    F3_SLL:  if (f7 == F7_BASE) v = a << rs2; else r.status = ST_ILLEGAL;
                    F3_SLTU: v = {31'd0, a < imm_i};
                    F3_XOR:  v = a ^ imm_i;
                    F3_SR: begin
                        if (f7 == F7_BASE) v = a >> rs2;
                        else if (f7 == F7_ALT) v = $signed(a) >>> rs2;
                        else r.status = ST_ILLEGAL;
                    end
                    F3_OR:   v = a | imm_i;
                    F3_AND:  v = a & imm_i;
                    default: r.status = ST_ILLEGAL;
                endcase
            end
            OPC_OP: begin
                dowrite = 1'b1;
                if (f7 == F7_BASE) begin
                    case (f3)
                        F3_ADD:  v = a + bv;
                        F3_SLL:  v = a << bv[4:0];
                        F3_SLTU: v = {31'd0, a < bv};
                        F3_XOR:  v = a ^ bv;
                        F3_OR:   v = a | bv;
                        F3_AND:  v = a & bv;
                        default: r.status = ST_ILLEGAL;
                    endcase
                end else if (f7 == F7_ALT && f3 == F3_ADD) begin
                    v = a - bv;
                end else if (f7 == F7_MULDIV && muldiv_on) begin
                    case (f3)
                        F3_MUL:  v = a * bv;
                        F3_MULH: begin
                            prod = $signed({{32{a[31]}}, a}) * $signed({{32{bv[31]}}, bv});
                            v = prod[63:32];
                        end
                        F3_DIV, F3_REM: begin
                            // divide by zero and overflow follow the ISA fixed results
                            if (bv == 32'd0)
                                v = (f3 == F3_REM) ? a : 32'hFFFF_FFFF;
                            else if (a == 32'h8000_0000 && bv == 32'hFFFF_FFFF)
                                v = (f3 == F3_REM) ? 32'd0 : 32'h8000_0000;
                            else if (f3 == F3_REM)
                                v = $signed(a) % $signed(bv);
                            else
                                v = $signed(a) / $signed(bv);
                        end
                        default: r.status = ST_ILLEGAL;
                    endcase
                end else begin
                    r.status = ST_ILLEGAL;
                end
            end
            OPC_LUI: begin
                dowrite = 1'b1;
                v = {w[31:12], 12'd0};
            end
            OPC_AUIPC: begin
                dowrite = 1'b1;
                v = {w[31:12], 12'd0} + pc;
            end
            OPC_JAL: begin
                imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                dowrite   = 1'b1;
                v         = pc + 32'd4;
                r.next_pc = pc + imm;
            end
            OPC_JALR: begin
                dowrite   = 1'b1;
                v         = pc + 32'd4;
                r.next_pc = (a + imm_i) & ~32'd1;
            end
            OPC_BRANCH: begin
                imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                case (f3)
                    F3_BEQ:  take = (a == bv);
                    F3_BNE:  take = (a != bv);
                    F3_BLT:  take = ($signed(a) < $signed(bv));
                    F3_BGE:  take = ($signed(a) >= $signed(bv));
                    F3_BLTU: take = (a < bv);
                    F3_BGEU: take = (a >= bv);
                    default: r.status = ST_ILLEGAL;
                endcase
                if (take) r.next_pc = pc + imm;
            end
            OPC_LOAD: begin
                case (f3)
                    F3_LBU: begin load_kind = LK_LBU; r.mem_size = SZ_BYTE; end
                    F3_LH:  begin load_kind = LK_LH;  r.mem_size = SZ_HALF; end
                    F3_LHU: begin load_kind = LK_LHU; r.mem_size = SZ_HALF; end
                    F3_LW:  begin load_kind = LK_LW;  r.mem_size = SZ_WORD; end
                    default: r.status = ST_ILLEGAL;
                endcase
                if (r.status == ST_OK) begin
                    r.mem_kind = MK_LOAD;
                    r.mem_addr = a + imm_i;
                    load_busy  = 1'b1;
                    load_dest  = rd;
                end
            end
            OPC_STORE: begin
                if (f3 <= F3_SW) begin
                    r.mem_kind   = MK_STORE;
                    r.mem_size   = f3[1:0];
                    r.mem_addr   = a + {{20{w[31]}}, w[31:25], rd};
                    r.store_data = bv;
                end else begin
                    r.status = ST_ILLEGAL;
                end
            end
            OPC_FENCE: if (f3 > F3_FENCE_I) r.status = ST_ILLEGAL;
            OPC_SYSTEM: begin
                if (f3 == F3_PRIV) begin
                    if (w[31:20] == F12_ECALL) r.status = ST_ECALL;
                    else if (w[31:20] == F12_EBREAK) r.status = ST_EBREAK;
                    else if (!(f7 == F7_WFI && rs2 == RS2_WFI)) r.status = ST_ILLEGAL;
                end else if (f3 == F3_SYS_RSV) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    r.status = ST_CSR;
                end
            end
            default: r.status = ST_ILLEGAL;
        endcase
        if (r.status == ST_ILLEGAL) begin
            r.next_pc    = pc;
            r.mem_kind   = MK_NONE;
            r.mem_addr   = '0;
            r.mem_size   = SZ_BYTE;
            r.store_data = '0;
        end else if (dowrite && r.status == ST_OK) begin
            if (write_reg(rd, v)) begin
                r.rd_written = 1'b1;
                r.rd_index   = rd;
                r.rd_value   = v;
            end
        end
        prog_ctr = r.next_pc;
        return r;
    endfunction

    task automatic report(string what, logic [31:0] exp_val, logic [31:0] got_val);
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_val, got_val);
        fail_count++;
    endtask

    task automatic compare_result(out_item_t e, out_item_t g);
        if (e.next_pc !== g.next_pc)       report("next_pc", e.next_pc, g.next_pc);
        if (e.mem_kind !== g.mem_kind)     report("mem_kind", 32'(e.mem_kind), 32'(g.mem_kind));
        if (e.mem_addr !== g.mem_addr)     report("mem_addr", e.mem_addr, g.mem_addr);
        if (e.mem_size !== g.mem_size)     report("mem_size", 32'(e.mem_size), 32'(g.mem_size));
        if (e.store_data !== g.store_data) report("store_data", e.store_data, g.store_data);
        if (e.rd_written !== g.rd_written)
            report("rd_written", 32'(e.rd_written), 32'(g.rd_written));
        if (e.rd_index !== g.rd_index)     report("rd_index", 32'(e.rd_index), 32'(g.rd_index));
        if (e.rd_value !== g.rd_value)     report("rd_value", e.rd_value, g.rd_value);
        if (e.status !== g.status)         report("status", 32'(e.status), 32'(g.status));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (regs[k]) regs[k] = '0;
            prog_ctr  = '0;
            muldiv_on = 1'b0;
            load_busy = 1'b0;
            load_dest = '0;
            load_kind = LK_LBU;
            expected_results.delete();
        end else begin
            // compare before predicting; no beat returns in the cycle it enters
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0)
                    report("unexpected result beat, next_pc", 32'd0, m_data.next_pc);
                else
                    compare_result(expected_results.pop_front(), m_data);
            end
            if (s_valid && s_ready) expected_results.push_back(execute_beat(s_data));
            if (cfg_wr_en) begin
                if (cfg_index == CFG_START_ADDRESS) prog_ctr = cfg_data;
                else muldiv_on = cfg_data[0];
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import rv32ie_pkg::*;
    import rv32ie_tb_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending_count;
    logic        quiet;      // set for the closing phases: no gaps, no stalls
    int          stall_left = 0;

    rv32i_instruction_execute i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rv32ie_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: stall in bursts of random length; no new burst starts when quiet.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_ready    = 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Offer one beat; an idle burst may come first. Returns at the falling
    // edge after acceptance with valid still high, so the next beat can
    // follow back to back.
    task automatic send_beat(in_item_t item);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_data  = item;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_insn(logic [31:0] w);
        send_beat('{cmd: 1'b0, insn_word: w, load_word: $urandom()});
    endtask

    task automatic send_load_data(logic [31:0] lw);
        send_beat('{cmd: 1'b1, insn_word: $urandom(), load_word: lw});
    endtask

    // Drop valid and hold until every result is back, so the block is idle.
    task automatic drain;
        s_valid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic write_reg_cfg(logic idx, logic [31:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Mostly well-formed instructions with random fields; offsets keep the
    // pc word aligned most of the time so a phase runs deep.
    function automatic logic [31:0] random_insn();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(0, 12))
            0, 1: begin
                w[6:0] = OPC_OP_IMM;
                case ($urandom_range(0, 3))
                    0, 1: w[31:25] = F7_BASE;
                    2:    w[31:25] = F7_ALT;
                    default: ;
                endcase
            end
            2, 3: begin
                w[6:0] = OPC_OP;
                case ($urandom_range(0, 4))
                    0, 1: w[31:25] = F7_BASE;
                    2:    w[31:25] = F7_ALT;
                    3:    w[31:25] = F7_MULDIV;
                    default: ;
                endcase
            end
            4: w[6:0] = ($urandom_range(0, 1) == 0) ? OPC_LUI : OPC_AUIPC;
            5: begin
                w[6:0] = OPC_JAL;
                if ($urandom_range(0, 15) != 0) w[21] = 1'b0;
            end
            6: begin
                w[6:0] = OPC_JALR;
                if ($urandom_range(0, 15) != 0) w[21] = 1'b0;
                if ($urandom_range(0, 3) != 0) w[19:15] = 5'd0;
            end
            7: begin
                w[6:0] = OPC_BRANCH;
                if ($urandom_range(0, 15) != 0) w[8] = 1'b0;
            end
            8, 9: begin
                w[6:0] = OPC_LOAD;
                case ($urandom_range(0, 4))
                    0: w[14:12] = F3_LBU;
                    1: w[14:12] = F3_LH;
                    2: w[14:12] = F3_LHU;
                    3: w[14:12] = F3_LW;
                    default: ;
                endcase
            end
            10: begin
                w[6:0] = OPC_STORE;
                if ($urandom_range(0, 5) != 0) w[14:12] = 3'($urandom_range(0, 2));
            end
            11: begin
                if ($urandom_range(0, 2) == 0) begin
                    w[6:0] = OPC_FENCE;
                end else begin
                    w[6:0] = OPC_SYSTEM;
                    case ($urandom_range(0, 4))
                        0: w = {F12_ECALL, 13'd0, OPC_SYSTEM};
                        1: w = {F12_EBREAK, 13'd0, OPC_SYSTEM};
                        2: begin
                            w[14:12] = F3_PRIV;
                            w[31:25] = F7_WFI;
                            w[24:20] = RS2_WFI;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [31:0] w;
        logic [31:0] start;
        s_valid    = 1'b0;
        s_data     = '0;
        quiet      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_START_ADDRESS;
        cfg_data   = '0;
        aresetn    = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: misaligned start, then extremes and every special case.
        write_reg_cfg(CFG_START_ADDRESS, 32'h0000_0002);
        send_insn({12'd1, 5'd0, F3_ADD, 5'd1, OPC_OP_IMM});
        drain();
        write_reg_cfg(CFG_START_ADDRESS, 32'h0000_0100);
        write_reg_cfg(CFG_MULDIV_ENABLE, 32'd1);
        send_insn({12'hFFF, 5'd0, F3_ADD, 5'd1, OPC_OP_IMM});           // x1 = -1
        send_insn({12'h7FF, 5'd0, F3_ADD, 5'd2, OPC_OP_IMM});           // x2 = 0x7ff
        send_insn({20'h80000, 5'd3, OPC_LUI});                          // x3 = min int
        send_insn({F7_ALT, 5'd31, 5'd3, F3_SR, 5'd4, OPC_OP_IMM});      // arith shift
        send_insn({F7_BASE, 5'd31, 5'd3, F3_SR, 5'd5, OPC_OP_IMM});     // logical shift
        send_insn({F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd6, OPC_OP_IMM});
        send_insn({F7_MULDIV, 5'd1, 5'd3, F3_DIV, 5'd7, OPC_OP});       // overflow
        send_insn({F7_MULDIV, 5'd0, 5'd1, F3_DIV, 5'd8, OPC_OP});       // by zero
        send_insn({F7_MULDIV, 5'd0, 5'd3, F3_REM, 5'd9, OPC_OP});
        send_insn({F7_MULDIV, 5'd3, 5'd3, F3_MULH, 5'd10, OPC_OP});
        send_insn({12'd0, 5'd2, F3_LH, 5'd11, OPC_LOAD});
        send_load_data(32'hFFFF_8000);
        send_insn({12'hFFF, 5'd2, F3_LW, 5'd0, OPC_LOAD});              // load to x0
        send_load_data(32'hFFFF_FFFF);
        send_insn({12'd1, 5'd2, F3_LBU, 5'd12, OPC_LOAD});
        send_insn({12'd1, 5'd0, F3_ADD, 5'd13, OPC_OP_IMM});            // ignored: busy
        send_load_data(32'h0000_00FF);
        send_load_data(32'h1234_5678);                                  // stray data
        send_insn({F12_EBREAK, 13'd0, OPC_SYSTEM});
        send_insn({F12_ECALL, 13'd0, OPC_SYSTEM});
        send_insn({12'h300, 5'd1, F3_CSRRW, 5'd14, OPC_SYSTEM});
        send_insn({F7_WFI, RS2_WFI, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM});
        send_insn({12'h0FF, 5'd0, F3_ADD, 5'd0, OPC_FENCE});
        send_insn(32'hFFFF_FFFF);                                       // illegal
        send_insn({7'h7F, 5'd1, 5'd3, F3_SW, 5'h1F, OPC_STORE});
        send_insn({1'b0, 6'd0, 5'd0, 5'd1, F3_BGE, 4'd4, 1'b0, OPC_BRANCH});
        send_insn({F7_BASE, 5'd0, 5'd1, F3_BGE, 5'd0, OPC_BRANCH});
        drain();
        write_reg_cfg(CFG_MULDIV_ENABLE, 32'd0);
        send_insn({F7_MULDIV, 5'd1, 5'd3, F3_MUL, 5'd15, OPC_OP});      // now illegal

        // Random phases; each opens with a fresh start address and mode.
        for (int phase = 0; phase < 20; phase++) begin
            drain();
            quiet = (phase >= 17);
            start = $urandom() & ~32'd3;
            case (phase % 5)
                0: start = 32'h0000_0000;
                1: start = 32'hFFFF_FFFC;
                2: if (phase == 7) start = $urandom();
                default: ;
            endcase
            write_reg_cfg(CFG_START_ADDRESS, start);
            write_reg_cfg(CFG_MULDIV_ENABLE, {31'd0, phase[0]});
            repeat (34) begin
                w = random_insn();
                send_insn(w);
                if (w[6:0] == OPC_LOAD) begin
                    if ($urandom_range(0, 7) == 0) send_insn(random_insn());
                    send_load_data($urandom());
                end else if ($urandom_range(0, 29) == 0) begin
                    send_load_data($urandom());
                end
            end
            // clear any load still waiting before the next setting
            send_load_data($urandom());
        end
        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #8000000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rv32ie_pkg.sv
sv/rv32ie_front.sv
sv/rv32ie_fifo.sv
sv/rv32ie_div.sv
sv/rv32ie_back.sv
sv/rv32i_instruction_execute.sv
tb/rv32ie_tb_pkg.sv
tb/rv32ie_checker.sv
tb/tb_top.sv
